// ----- hdl/dual_solenoid_pwm_controller_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef DUAL_SOLENOID_PWM_CONTROLLER_UNIT_DEFINES_SVH
`define DUAL_SOLENOID_PWM_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define DSPC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dspc assertion failed");

// next-cycle implication, off during reset
`define DSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dspc assertion failed");

// next-cycle implication that also holds across reset
`define DSPC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dspc assertion failed");

`endif

// ----- hdl/dspc_pkg.sv -----
// shared constants, types and arithmetic helpers of the solenoid pwm controller
`default_nettype none

package dspc_pkg;

    localparam logic [1:0] DUTY_SCALE    = 2'd2;
    localparam logic [2:0] CLUTCH_A_BIT  = 3'd0;
    localparam logic [2:0] CLUTCH_B_BIT  = 3'd1;
    localparam logic [2:0] UPSHIFT_BIT   = 3'd2;
    localparam logic [2:0] DOWNSHIFT_BIT = 3'd3;

    localparam logic [6:0] FULL_PCT   = 7'd100;
    localparam logic [7:0] LATCH_INIT = 8'hff;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_SAMPLE    = 3'd1;
    localparam logic [2:0] CMD_TARGET    = 3'd2;
    localparam logic [2:0] CMD_UPSHIFT   = 3'd3;
    localparam logic [2:0] CMD_DOWNSHIFT = 3'd4;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    typedef logic [6:0] t_pct;

    typedef struct packed {
        logic [7:0] drive_byte;
        logic [7:0] compare_value;
    } t_result;

    // compare interval for a percentage, kept to 8 bits
    function automatic logic [7:0] f_interval(input logic [7:0] pct);
        logic [9:0] prod;
        prod = 10'(pct) * 10'(DUTY_SCALE);
        f_interval = prod[7:0];
    endfunction

    // floor(smp * 100 / 255) by reciprocal with correction
    function automatic t_pct f_to_pct(input logic [7:0] smp);
        logic [14:0] prod;
        logic [15:0] sum;
        prod = 15'(smp) * 15'(FULL_PCT);
        sum  = 16'(prod) + 16'(prod[14:8]) + 16'd1;
        f_to_pct = sum[14:8];
    endfunction

    function automatic logic [7:0] f_set_bit(input logic [7:0] bits, input logic [2:0] idx,
                                             input logic val);
        logic [7:0] res;
        res      = bits;
        res[idx] = val;
        f_set_bit = res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dspc_ctrl.sv -----
// controller state, command decode and three-phase sequencer
`default_nettype none

module dspc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [2:0]        i_command,
    input  wire logic [7:0]        i_sample,
    input  wire logic [6:0]        i_target,
    input  wire logic              i_level,
    output logic                   o_push,
    output dspc_pkg::t_result      o_result
);
    import dspc_pkg::*;

    t_pct       r_duty_a, n_duty_a;
    t_pct       r_duty_b, n_duty_b;
    t_pct       r_target, n_target;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_latch, n_latch;

    logic [7:0] a8, b8;
    logic [7:0] full_minus_a, full_minus_b;
    logic [7:0] cmp;
    t_pct       pos;

    always_comb begin
        a8           = {1'b0, r_duty_a};
        b8           = {1'b0, r_duty_b};
        full_minus_a = {1'b0, FULL_PCT} - a8;
        full_minus_b = {1'b0, FULL_PCT} - b8;
        pos          = f_to_pct(i_sample);

        n_duty_a = r_duty_a;
        n_duty_b = r_duty_b;
        n_target = r_target;
        n_phase  = r_phase;
        n_latch  = r_latch;
        cmp      = '0;
        o_push   = 1'b0;

        if (i_fire) begin
            unique case (i_command)
                CMD_TICK: begin
                    o_push = 1'b1;
                    unique case (r_phase)
                        PH_FIRST: begin
                            if (r_duty_a > r_duty_b) begin
                                if (r_duty_a == FULL_PCT) begin
                                    n_latch = f_set_bit(r_latch, CLUTCH_B_BIT, 1'b1);
                                    cmp     = f_interval(full_minus_b);
                                    n_phase = PH_IDLE;
                                end else if (r_duty_b == '0) begin
                                    n_latch = f_set_bit(r_latch, CLUTCH_A_BIT, 1'b1);
                                    cmp     = f_interval(full_minus_a);
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_latch = f_set_bit(r_latch, CLUTCH_B_BIT, 1'b1);
                                    cmp     = f_interval(a8 - b8);
                                    n_phase = PH_SECOND;
                                end
                            end else begin
                                if (r_duty_b == FULL_PCT) begin
                                    n_latch = f_set_bit(r_latch, CLUTCH_A_BIT, 1'b1);
                                    cmp     = f_interval(full_minus_a);
                                    n_phase = PH_IDLE;
                                end else if (r_duty_a == '0) begin
                                    n_latch = f_set_bit(r_latch, CLUTCH_B_BIT, 1'b1);
                                    cmp     = f_interval(full_minus_b);
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_latch = f_set_bit(r_latch, CLUTCH_A_BIT, 1'b1);
                                    cmp     = f_interval(b8 - a8);
                                    n_phase = PH_SECOND;
                                end
                            end
                        end
                        PH_SECOND: begin
                            if (r_duty_a > r_duty_b) begin
                                n_latch = f_set_bit(r_latch, CLUTCH_A_BIT, 1'b1);
                                cmp     = f_interval(full_minus_a);
                            end else begin
                                n_latch = f_set_bit(r_latch, CLUTCH_B_BIT, 1'b1);
                                cmp     = f_interval(full_minus_b);
                            end
                            n_phase = PH_IDLE;
                        end
                        default: begin
                            // idle phase, also covers the unreachable code
                            n_latch = f_set_bit(r_latch, CLUTCH_A_BIT, r_duty_a == '0);
                            n_latch = f_set_bit(n_latch, CLUTCH_B_BIT, r_duty_b == '0);
                            if ((r_duty_a > r_duty_b || r_duty_a == '0) && r_duty_b != '0) begin
                                cmp     = f_interval(b8);
                                n_phase = PH_FIRST;
                            end else if (r_duty_a != '0 && r_duty_a < FULL_PCT) begin
                                cmp     = f_interval(a8);
                                n_phase = PH_FIRST;
                            end else begin
                                cmp     = f_interval({1'b0, FULL_PCT});
                                n_phase = PH_IDLE;
                            end
                        end
                    endcase
                end
                CMD_SAMPLE: begin
                    if (r_target > pos) begin
                        n_duty_a = r_target - pos;
                        n_duty_b = '0;
                    end else if (r_target < pos) begin
                        n_duty_a = '0;
                        n_duty_b = pos - r_target;
                    end
                end
                CMD_TARGET: begin
                    n_target = (i_target > FULL_PCT) ? FULL_PCT : i_target;
                end
                CMD_UPSHIFT: begin
                    n_latch = f_set_bit(r_latch, UPSHIFT_BIT, i_level);
                end
                CMD_DOWNSHIFT: begin
                    n_latch = f_set_bit(r_latch, DOWNSHIFT_BIT, i_level);
                end
                default: begin
                end
            endcase
        end

        o_result.drive_byte    = n_latch;
        o_result.compare_value = cmp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_a <= '0;
            r_duty_b <= '0;
            r_target <= '0;
            r_phase  <= PH_IDLE;
            r_latch  <= LATCH_INIT;
        end else begin
            r_duty_a <= n_duty_a;
            r_duty_b <= n_duty_b;
            r_target <= n_target;
            r_phase  <= n_phase;
            r_latch  <= n_latch;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dspc_out_buf.sv -----
// two-entry result buffer that decouples the receiver from the input side
`default_nettype none

module dspc_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dspc_pkg::t_result i_data,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output dspc_pkg::t_result      o_data
);
    import dspc_pkg::*;

    logic [1:0] r_count, n_count;
    t_result    r_slot0, r_slot1;
    logic       pop;
    logic [1:0] wr_pos;

    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign o_data  = r_slot0;
    assign pop     = o_valid && i_ready;
    assign wr_pos  = r_count - {1'b0, pop};
    assign n_count = r_count + {1'b0, i_push} - {1'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (wr_pos == 2'd0)) begin
            r_slot0 <= i_data;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
        if (i_push && (wr_pos != 2'd0)) begin
            r_slot1 <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dual_solenoid_pwm_controller_unit.sv -----
// Dual clutch solenoid pwm sequencer with position controller, top level.
// Input channel: i_valid/o_ready carry one command word (i_command, i_sample,
// i_target, i_level). Output channel: o_valid/i_ready carry one result word
// (o_drive_byte, o_compare_value), produced only for timer tick commands.
// A command word is taken into an input register; once the output buffer has
// room it updates the controller state and a tick result is written to a
// two-entry output buffer, which drives o_valid. Throughput is one command
// word per clock while the output buffer has room; ticks sustain this while
// i_ready stays high.
// When the receiver stalls, results collect in the output buffer; once it is
// full the input register holds its word and o_ready drops until a result
// is taken. Shift commands change the drive byte seen from the next tick on.
// Synchronous active-low reset: duties and target cleared, phase idle, drive
// byte all ones, input register and output buffer empty.
`default_nettype none

module dual_solenoid_pwm_controller_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_command,
    input  wire logic [7:0] i_sample,
    input  wire logic [6:0] i_target,
    input  wire logic       i_level,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_drive_byte,
    output logic [7:0]      o_compare_value
);
    import dspc_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [2:0] r_command;
    logic [7:0] r_sample;
    logic [6:0] r_target;
    logic       r_level;

    logic    room;
    logic    advance;
    logic    take;
    logic    push;
    t_result result;
    t_result out_word;

    assign advance = r_in_valid && room;
    assign o_ready = !r_in_valid || room;
    assign take    = i_valid && o_ready;

    always_comb begin
        if (take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_command <= i_command;
            r_sample  <= i_sample;
            r_target  <= i_target;
            r_level   <= i_level;
        end
    end

    dspc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_command (r_command),
        .i_sample  (r_sample),
        .i_target  (r_target),
        .i_level   (r_level),
        .o_push    (push),
        .o_result  (result)
    );

    dspc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_word)
    );

    assign o_drive_byte    = out_word.drive_byte;
    assign o_compare_value = out_word.compare_value;

endmodule

`default_nettype wire

// ----- hdl/dspc_checker.sv -----
// port-level checks of the solenoid pwm controller and their bind
`default_nettype none

`include "dual_solenoid_pwm_controller_unit_defines.svh"

module dspc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_drive_byte,
    input wire logic [7:0] o_compare_value
);
    import dspc_pkg::*;

    logic [7:0] max_compare;

    assign max_compare = f_interval({1'b0, FULL_PCT});

    // a stalled result word holds
    `DSPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_drive_byte) && $stable(o_compare_value))

    // buffer comes out of reset empty
    `DSPC_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_valid)

    // input side only stalls behind waiting results
    `DSPC_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, !o_ready, o_valid)

    // compare interval never exceeds a full period
    `DSPC_ASSERT_IMPLY(a_cmp_range, i_clk, i_rst_n, o_valid, o_compare_value <= max_compare)

endmodule

bind dual_solenoid_pwm_controller_unit dspc_checker u_dspc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_drive_byte    (o_drive_byte),
    .o_compare_value (o_compare_value)
);

`default_nettype wire

// ----- dv/dual_solenoid_pwm_controller_unit_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the dual solenoid pwm controller: directed table, then paced random words

module dual_solenoid_pwm_controller_unit_test;

    import dspc_pkg::*;

    localparam logic [2:0] CMD_FIRST_UNUSED = CMD_DOWNSHIFT + 3'd1;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;
    localparam int         DIRECTED_COUNT   = 25;
    localparam int         RANDOM_PER_PHASE = 585;
    localparam int         HOLD_CYCLES      = 64;
    localparam int         DRAIN_CYCLES     = 8;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] smp;
        logic [6:0] tgt;
        logic       lvl;
        logic       typed;
        t_result    res;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [2:0] i_command;
    logic [7:0] i_sample;
    logic [6:0] i_target;
    logic       i_level;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_drive_byte;
    logic [7:0] o_compare_value;

    // controller state as the block should hold it
    t_pct       duty_a;
    t_pct       duty_b;
    logic [1:0] seq_phase;
    logic [7:0] drive_bits;
    t_pct       target_pct;

    t_result    pending_results[$];
    t_result    want;
    int         mismatch_count;
    int         results_checked;
    int         words_sent;
    int         stall_cycles;
    int         tx_idle_pct = 25;
    int         rx_idle_pct = 84;
    bit         hold_request;

    t_stim_row directed_rows [DIRECTED_COUNT] = '{
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b1, '{8'hff, 8'hc8}},
        '{CMD_LAST_UNUSED,  8'hff, 7'h7f, 1'b1, 1'b0, '{8'h00, 8'h00}},
        '{CMD_FIRST_UNUSED, 8'hff, 7'h7f, 1'b1, 1'b0, '{8'h00, 8'h00}},
        '{CMD_UPSHIFT,      8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_DOWNSHIFT,    8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b1, '{8'hf3, 8'hc8}},
        '{CMD_UPSHIFT,      8'h00, 7'h00, 1'b1, 1'b0, '{8'h00, 8'h00}},
        '{CMD_DOWNSHIFT,    8'h00, 7'h00, 1'b1, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TARGET,       8'h00, 7'h7f, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_SAMPLE,       8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b1, '{8'hfe, 8'hc8}},
        '{CMD_TARGET,       8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_SAMPLE,       8'hff, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TARGET,       8'h00, 7'd50, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_SAMPLE,       8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_SAMPLE,       8'd128, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_SAMPLE,       8'd200, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TICK,         8'h00, 7'h00, 1'b0, 1'b0, '{8'h00, 8'h00}},
        '{CMD_TARGET,       8'h00, 7'd100, 1'b0, 1'b0, '{8'h00, 8'h00}}
    };

    dual_solenoid_pwm_controller_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_sample        (i_sample),
        .i_target        (i_target),
        .i_level         (i_level),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_drive_byte    (o_drive_byte),
        .o_compare_value (o_compare_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want_v);
        $display("mismatch on result %0d: %s got %02h want %02h",
                 results_checked, what, got, want_v);
        mismatch_count++;
    endtask

    // one timer tick of the three-phase sequencer, returns the compare interval
    function automatic logic [7:0] step_sequencer();
        int a;
        int b;
        int pct;
        int full;
        full = int'(FULL_PCT);
        a    = int'(duty_a);
        b    = int'(duty_b);
        case (seq_phase)
            PH_FIRST: begin
                if (a > b) begin
                    if (a == full) begin
                        drive_bits[CLUTCH_B_BIT] = 1'b1;
                        pct = full - b;
                        seq_phase = PH_IDLE;
                    end else if (b == 0) begin
                        drive_bits[CLUTCH_A_BIT] = 1'b1;
                        pct = full - a;
                        seq_phase = PH_IDLE;
                    end else begin
                        drive_bits[CLUTCH_B_BIT] = 1'b1;
                        pct = a - b;
                        seq_phase = PH_SECOND;
                    end
                end else begin
                    if (b == full) begin
                        drive_bits[CLUTCH_A_BIT] = 1'b1;
                        pct = full - a;
                        seq_phase = PH_IDLE;
                    end else if (a == 0) begin
                        drive_bits[CLUTCH_B_BIT] = 1'b1;
                        pct = full - b;
                        seq_phase = PH_IDLE;
                    end else begin
                        drive_bits[CLUTCH_A_BIT] = 1'b1;
                        pct = b - a;
                        seq_phase = PH_SECOND;
                    end
                end
            end
            PH_SECOND: begin
                if (a > b) begin
                    drive_bits[CLUTCH_A_BIT] = 1'b1;
                    pct = full - a;
                end else begin
                    drive_bits[CLUTCH_B_BIT] = 1'b1;
                    pct = full - b;
                end
                seq_phase = PH_IDLE;
            end
            default: begin
                drive_bits[CLUTCH_A_BIT] = (a == 0);
                drive_bits[CLUTCH_B_BIT] = (b == 0);
                if ((a > b || a == 0) && b > 0) begin
                    pct = b;
                    seq_phase = PH_FIRST;
                end else if (a > 0 && a < full) begin
                    pct = a;
                    seq_phase = PH_FIRST;
                end else begin
                    pct = full;
                    seq_phase = PH_IDLE;
                end
            end
        endcase
        return 8'(pct * int'(DUTY_SCALE));
    endfunction

    // updates the predicted state for one word, returns 1 when a result is due
    function automatic bit apply_command(input logic [2:0] cmd, input logic [7:0] smp,
                                         input logic [6:0] tgt, input logic lvl,
                                         output t_result res);
        int pos;
        int tpos;
        res = '0;
        case (cmd)
            CMD_TICK: begin
                res.compare_value = step_sequencer();
                res.drive_byte    = drive_bits;
                return 1'b1;
            end
            CMD_SAMPLE: begin
                pos  = int'(smp) * int'(FULL_PCT) / 255;
                tpos = int'(target_pct);
                if (tpos > pos) begin
                    duty_a = t_pct'(tpos - pos);
                    duty_b = '0;
                end else if (tpos < pos) begin
                    duty_a = '0;
                    duty_b = t_pct'(pos - tpos);
                end
            end
            CMD_TARGET: target_pct = (tgt > FULL_PCT) ? FULL_PCT : tgt;
            CMD_UPSHIFT: drive_bits[UPSHIFT_BIT] = lvl;
            CMD_DOWNSHIFT: drive_bits[DOWNSHIFT_BIT] = lvl;
            default: ;
        endcase
        return 1'b0;
    endfunction

    // offers one word from a falling edge, returns at the falling edge after it is taken
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] smp,
                             input logic [6:0] tgt, input logic lvl,
                             input logic typed, input t_result typed_res);
        t_result predicted;
        bit      produces;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid   <= 1'b0;
            i_command <= 3'($urandom);
            i_sample  <= 8'($urandom);
            i_target  <= 7'($urandom);
            i_level   <= 1'($urandom);
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_sample  <= smp;
        i_target  <= tgt;
        i_level   <= lvl;
        do @(posedge i_clk); while (!o_ready);
        produces = apply_command(cmd, smp, tgt, lvl, predicted);
        if (produces) begin
            pending_results.push_back(typed ? typed_res : predicted);
        end
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_random_word(output bit counted);
        int         pick;
        logic [2:0] cmd;
        logic [7:0] smp;
        logic [6:0] tgt;
        logic       lvl;
        pick = $urandom_range(0, 99);
        smp  = 8'($urandom);
        tgt  = 7'($urandom);
        lvl  = 1'($urandom);
        if (pick < 40) begin
            cmd = CMD_TICK;
        end else if (pick < 70) begin
            cmd  = CMD_SAMPLE;
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                smp = pick[0] ? 8'hff : 8'h00;
            end else if (pick < 4) begin
                // lands exactly on the target, zero error
                smp = 8'((int'(target_pct) * 255 + 99) / 100);
            end
        end else if (pick < 82) begin
            cmd  = CMD_TARGET;
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                tgt = 7'($urandom_range(0, int'(FULL_PCT)));
            end else if (pick < 8) begin
                tgt = 7'($urandom_range(int'(FULL_PCT) + 1, 127));
            end else begin
                case ($urandom_range(0, 2))
                    0: tgt = 7'h00;
                    1: tgt = FULL_PCT;
                    default: tgt = 7'h7f;
                endcase
            end
        end else if (pick < 88) begin
            cmd = CMD_UPSHIFT;
        end else if (pick < 94) begin
            cmd = CMD_DOWNSHIFT;
        end else begin
            cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        end
        counted = (cmd <= CMD_DOWNSHIFT);
        send_word(cmd, smp, tgt, lvl, 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // receiver pacing, with one long hold-off on request
    initial begin
        int n;
        i_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    i_ready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_ready) begin
                stall_cycles++;
            end
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result, drive byte", o_drive_byte, 8'h00);
                end else begin
                    want = pending_results.pop_front();
                    if (o_drive_byte !== want.drive_byte) begin
                        report_mismatch("drive byte", o_drive_byte, want.drive_byte);
                    end
                    if (o_compare_value !== want.compare_value) begin
                        report_mismatch("compare value", o_compare_value, want.compare_value);
                    end
                end
                results_checked++;
            end
        end
    end

    initial begin
        int ph;
        int r;
        int sent;
        bit counted;
        duty_a          = '0;
        duty_b          = '0;
        seq_phase       = PH_IDLE;
        drive_bits      = LATCH_INIT;
        target_pct      = '0;
        mismatch_count  = 0;
        results_checked = 0;
        words_sent      = 0;
        stall_cycles    = 0;
        hold_request    = 1'b0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_command <= CMD_TICK;
        i_sample  <= 8'h00;
        i_target  <= 7'h00;
        i_level   <= 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < DIRECTED_COUNT; r++) begin
            send_word(directed_rows[r].cmd, directed_rows[r].smp, directed_rows[r].tgt,
                      directed_rows[r].lvl, directed_rows[r].typed, directed_rows[r].res);
        end
        i_valid <= 1'b0;
        wait_drained();

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 84 : 0;
            rx_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 25 : 0;
            // receiver stops for a while, the input side must back up
            if (ph == 2) begin
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                send_random_word(counted);
                if (counted) begin
                    sent++;
                end
            end
            i_valid <= 1'b0;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d command words and %0d tick results over three pacing modes",
                 words_sent, results_checked);
        $display("input side held off for %0d cycles while offering a word", stall_cycles);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
